### sv/c_subset_lexer_core_assert.svh
// assertion macros for the lexer
`ifndef C_SUBSET_LEXER_CORE_ASSERT_SVH
`define C_SUBSET_LEXER_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define LEX_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("lexer check failed");
// implication whose consequent is checked in the cycle after the antecedent
`define LEX_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("lexer check failed");
`endif

### sv/csl_pkg.sv
// ----------------------------------------------------------------------------
// csl_pkg
// codes, defaults and helper functions shared by the lexer core and its bench
// ----------------------------------------------------------------------------
package csl_pkg;
	localparam int POSITION_BITS_DEF = 16;
	localparam int VALUE_BITS_DEF = 31;

	localparam logic [2:0] MODE_IDLE  = 3'd0;
	localparam logic [2:0] MODE_WORD  = 3'd1;
	localparam logic [2:0] MODE_NUM   = 3'd2;
	localparam logic [2:0] MODE_STR   = 3'd3;
	localparam logic [2:0] MODE_OPER  = 3'd4;
	localparam logic [2:0] MODE_LINE  = 3'd5;
	localparam logic [2:0] MODE_BLOCK = 3'd6;

	localparam logic [3:0] KIND_IDENT  = 4'd0;
	localparam logic [3:0] KIND_NUMBER = 4'd1;
	localparam logic [3:0] KIND_STRING = 4'd2;
	localparam logic [3:0] KIND_OPER   = 4'd3;
	localparam logic [3:0] KIND_KW0    = 4'd4;
	localparam logic [3:0] KIND_END    = 4'd13;
	localparam logic [3:0] KIND_ERROR  = 4'd14;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_COMMENT = 2'd1;
	localparam logic [1:0] ERR_STRING  = 2'd2;
	localparam logic [1:0] ERR_BADCHAR = 2'd3;

	localparam logic [4:0] OP_NONE = 5'd0;

	localparam int NUM_KW = 9;

	function automatic logic [7:0] kw_char(input int unsigned k, input int unsigned i);
		logic [7:0] r;
		logic [47:0] w;
		r = 8'd0;
		unique case (k)
			0: w = "return";
			1: w = {"if", 32'd0};
			2: w = {"else", 16'd0};
			3: w = {"for", 24'd0};
			4: w = {"while", 8'd0};
			5: w = {"int", 24'd0};
			6: w = {"char", 16'd0};
			7: w = {"void", 16'd0};
			default: w = "sizeof";
		endcase
		r = w[8'(47 - 8 * i) -: 8];
		return r;
	endfunction

	function automatic logic [2:0] kw_len(input int unsigned k);
		logic [2:0] r;
		unique case (k)
			0, 8: r = 3'd6;
			1: r = 3'd2;
			2, 6, 7: r = 3'd4;
			3, 5: r = 3'd3;
			default: r = 3'd5;
		endcase
		return r;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [4:0] single_code(input logic [7:0] c, output logic hit);
		logic [4:0] r;
		hit = 1'b1;
		r = 5'd0;
		unique case (c)
			"+": r = 5'd0;
			"-": r = 5'd1;
			"*": r = 5'd2;
			"/": r = 5'd3;
			"(": r = 5'd4;
			")": r = 5'd5;
			"<": r = 5'd6;
			">": r = 5'd7;
			";": r = 5'd8;
			"=": r = 5'd9;
			"{": r = 5'd10;
			"}": r = 5'd11;
			"&": r = 5'd12;
			",": r = 5'd13;
			"[": r = 5'd14;
			"]": r = 5'd15;
			default: hit = 1'b0;
		endcase
		return r;
	endfunction
endpackage

### sv/c_subset_lexer_core.sv
// ----------------------------------------------------------------------------
// c_subset_lexer_core
// byte-in, token-out lexer for a small subset of c
// ----------------------------------------------------------------------------
//  channel  valid     stall     payload
//  in       in_valid  in_stall  text_byte, end_of_text
//  out      out_valid out_stall token_kind .. last_result
//
//  one byte per cycle while in_stall is low; one logic stage scans each byte
//  into up to two tokens, which enter an eight-word output queue next cycle.
//  in_stall rises once more than one word waits in the queue.
//  reset clears the scan state and empties the queue.
module c_subset_lexer_core #(
	parameter int POSITION_BITS = csl_pkg::POSITION_BITS_DEF,
	parameter int VALUE_BITS = csl_pkg::VALUE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [7:0]               text_byte,
	input  logic                     end_of_text,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [3:0]               token_kind,
	output logic [4:0]               operator_code,
	output logic [POSITION_BITS-1:0] start_offset,
	output logic [POSITION_BITS-1:0] token_length,
	output logic [VALUE_BITS-1:0]    number_value,
	output logic [1:0]               error_code,
	output logic                     last_result
);
	import csl_pkg::*;
	`include "c_subset_lexer_core_assert.svh"
	localparam int PB = POSITION_BITS;
	localparam int VB = VALUE_BITS;
	localparam int TW = 4 + 5 + PB + PB + VB + 2 + 1;

	typedef struct packed {
		logic [3:0]    kind;
		logic [4:0]    op;
		logic [PB-1:0] start;
		logic [PB-1:0] len;
		logic [VB-1:0] val;
		logic [1:0]    err;
		logic          last;
	} tok_t;

	logic [2:0]    mode_q;
	logic [8:0]    cand_q;
	logic [PB-1:0] tstart_q;
	logic [PB-1:0] pos_q;
	logic [VB-1:0] acc_q;
	logic [7:0]    pend_q;
	logic          star_q;

	logic [1:0] cnt_s1;
	tok_t       tok_s1 [3];

	logic [2:0] mode_d;
	logic [8:0] cand_d;
	logic [PB-1:0] tstart_d;
	logic [PB-1:0] pos_d;
	logic [VB-1:0] acc_d;
	logic [7:0] pend_d;
	logic star_d;
	logic [1:0] cnt_d;
	tok_t tok_d [3];

	logic accept;
	logic [2:0] free_slots;
	logic [TW-1:0] push_data [3];
	logic [TW-1:0] pop_data;
	tok_t out_tok;

	assign in_stall = free_slots < 3'd6;
	assign accept = in_valid && !in_stall;

	function automatic tok_t mk(input logic [3:0] k, input logic [4:0] o,
		input logic [PB-1:0] s, input logic [PB-1:0] l,
		input logic [VB-1:0] v, input logic [1:0] e);
		tok_t t;
		t.kind = k;
		t.op = o;
		t.start = s;
		t.len = l;
		t.val = v;
		t.err = e;
		t.last = 1'b0;
		return t;
	endfunction

	always_comb begin
		logic [7:0] c;
		logic [PB-1:0] span;
		logic [3:0] wkind;
		logic [4:0] sc;
		logic shit;
		logic [4:0] pc;
		logic phit;
		logic go_idle;
		logic [4:0] dc;
		logic dhit;
		logic [VB+3:0] prod;
		logic [PB-1:0] idx;
		logic [3:0] d;
		c = text_byte;
		span = PB'(pos_q - tstart_q);
		mode_d = mode_q;
		cand_d = cand_q;
		tstart_d = tstart_q;
		pos_d = pos_q;
		acc_d = acc_q;
		pend_d = pend_q;
		star_d = star_q;
		cnt_d = 2'd0;
		for (int i = 0; i < 3; i++) begin
			tok_d[i] = '0;
		end
		wkind = KIND_IDENT;
		for (int k = 0; k < NUM_KW; k++) begin
			if (cand_q[k] && span == PB'(kw_len(k))) begin
				wkind = 4'(KIND_KW0 + 4'(k));
			end
		end
		sc = single_code(c, shit);
		pc = single_code(pend_q, phit);
		dhit = 1'b1;
		dc = OP_NONE;
		if (c == "=" && pend_q == "=") dc = 5'd16;
		else if (c == "=" && pend_q == "!") dc = 5'd17;
		else if (c == "=" && pend_q == "<") dc = 5'd18;
		else if (c == "=" && pend_q == ">") dc = 5'd19;
		else if (c == "+" && pend_q == "+") dc = 5'd20;
		else if (c == "-" && pend_q == "-") dc = 5'd21;
		else dhit = 1'b0;
		d = 4'(c - "0");
		prod = (VB + 4)'(acc_q) * (VB + 4)'(10) + (VB + 4)'(d);
		idx = span;
		go_idle = 1'b0;
		if (end_of_text) begin
			unique case (mode_q)
				MODE_WORD: begin
					tok_d[0] = mk(wkind, OP_NONE, tstart_q, span, '0, ERR_NONE);
					cnt_d = 2'd1;
				end
				MODE_NUM: begin
					tok_d[0] = mk(KIND_NUMBER, OP_NONE, tstart_q, span, acc_q, ERR_NONE);
					cnt_d = 2'd1;
				end
				MODE_OPER: begin
					tok_d[0] = phit ? mk(KIND_OPER, pc, tstart_q, PB'(1), '0, ERR_NONE)
						: mk(KIND_ERROR, OP_NONE, tstart_q, PB'(1), '0, ERR_BADCHAR);
					cnt_d = 2'd1;
				end
				MODE_STR: begin
					tok_d[0] = mk(KIND_ERROR, OP_NONE, tstart_q, span, '0, ERR_STRING);
					cnt_d = 2'd1;
				end
				MODE_BLOCK: begin
					tok_d[0] = mk(KIND_ERROR, OP_NONE, tstart_q, span, '0, ERR_COMMENT);
					cnt_d = 2'd1;
				end
				default: ;
			endcase
			tok_d[cnt_d] = mk(KIND_END, OP_NONE, pos_q, '0, '0, ERR_NONE);
			cnt_d = 2'(cnt_d + 2'd1);
			mode_d = MODE_IDLE;
			cand_d = '0;
			tstart_d = '0;
			pos_d = '0;
			acc_d = '0;
			pend_d = '0;
			star_d = 1'b0;
		end else begin
			pos_d = PB'(pos_q + PB'(1));
			unique case (mode_q)
				MODE_WORD: begin
					if (is_letter(c)) begin
						for (int k = 0; k < NUM_KW; k++) begin
							if (!(idx < PB'(kw_len(k)) && kw_char(k, 32'(idx[2:0])) == c))
								cand_d[k] = 1'b0;
						end
					end else begin
						tok_d[0] = mk((is_digit(c) || c == "_") ? KIND_IDENT : wkind,
							OP_NONE, tstart_q, span, '0, ERR_NONE);
						cnt_d = 2'd1;
						go_idle = 1'b1;
					end
				end
				MODE_NUM: begin
					if (is_digit(c)) begin
						acc_d = (prod[VB+3:VB] != '0) ? '1 : prod[VB-1:0];
					end else begin
						tok_d[0] = mk(KIND_NUMBER, OP_NONE, tstart_q, span, acc_q, ERR_NONE);
						cnt_d = 2'd1;
						go_idle = 1'b1;
					end
				end
				MODE_STR: begin
					if (c == "\"") begin
						tok_d[0] = mk(KIND_STRING, OP_NONE, tstart_q, PB'(span + PB'(1)),
							'0, ERR_NONE);
						cnt_d = 2'd1;
						mode_d = MODE_IDLE;
					end
				end
				MODE_OPER: begin
					if (dhit) begin
						tok_d[0] = mk(KIND_OPER, dc, tstart_q, PB'(2), '0, ERR_NONE);
						cnt_d = 2'd1;
						mode_d = MODE_IDLE;
					end else if (pend_q == "/" && c == "/") begin
						mode_d = MODE_LINE;
					end else if (pend_q == "/" && c == "*") begin
						mode_d = MODE_BLOCK;
						star_d = 1'b0;
					end else begin
						tok_d[0] = phit ? mk(KIND_OPER, pc, tstart_q, PB'(1), '0, ERR_NONE)
							: mk(KIND_ERROR, OP_NONE, tstart_q, PB'(1), '0, ERR_BADCHAR);
						cnt_d = 2'd1;
						go_idle = 1'b1;
					end
				end
				MODE_LINE: begin
					if (c == 8'd10) mode_d = MODE_IDLE;
				end
				MODE_BLOCK: begin
					if (star_q && c == "/") mode_d = MODE_IDLE;
					star_d = c == "*";
				end
				default: go_idle = 1'b1;
			endcase
			if (go_idle) begin
				mode_d = MODE_IDLE;
				if (is_space(c)) begin
				end else if (is_letter(c)) begin
					mode_d = MODE_WORD;
					tstart_d = pos_q;
					for (int k = 0; k < NUM_KW; k++) begin
						cand_d[k] = kw_char(k, 0) == c;
					end
				end else if (is_digit(c)) begin
					mode_d = MODE_NUM;
					tstart_d = pos_q;
					acc_d = (VB > 3) ? VB'(d) : ((VB'(d) > VB'('1)) ? '1 : VB'(d));
				end else if (c == "\"") begin
					mode_d = MODE_STR;
					tstart_d = pos_q;
				end else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "+"
					|| c == "-" || c == "/") begin
					mode_d = MODE_OPER;
					tstart_d = pos_q;
					pend_d = c;
				end else begin
					tok_d[cnt_d] = shit ? mk(KIND_OPER, sc, pos_q, PB'(1), '0, ERR_NONE)
						: mk(KIND_ERROR, OP_NONE, pos_q, PB'(1), '0, ERR_BADCHAR);
					cnt_d = 2'(cnt_d + 2'd1);
				end
			end
		end
		if (cnt_d != 2'd0) begin
			tok_d[2'(cnt_d - 2'd1)].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			cand_q <= '0;
			tstart_q <= '0;
			pos_q <= '0;
			acc_q <= '0;
			pend_q <= '0;
			star_q <= 1'b0;
			cnt_s1 <= 2'd0;
		end else begin
			cnt_s1 <= accept ? cnt_d : 2'd0;
			if (accept) begin
				mode_q <= mode_d;
				cand_q <= cand_d;
				tstart_q <= tstart_d;
				pos_q <= pos_d;
				acc_q <= acc_d;
				pend_q <= pend_d;
				star_q <= star_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			tok_s1[i] <= tok_d[i];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			push_data[i] = tok_s1[i];
		end
	end

	csl_outq #(.WIDTH(TW)) u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push_count(cnt_s1),
		.push_data(push_data),
		.free_slots(free_slots),
		.valid(out_valid),
		.stall(out_stall),
		.data(pop_data)
	);

	assign out_tok = pop_data;
	assign token_kind = out_tok.kind;
	assign operator_code = out_tok.op;
	assign start_offset = out_tok.start;
	assign token_length = out_tok.len;
	assign number_value = out_tok.val;
	assign error_code = out_tok.err;
	assign last_result = out_tok.last;

	`LEX_ASSERT_NEXT(a_eot_clears, clk, arst_n, accept && end_of_text,
		pos_q == '0 && mode_q == MODE_IDLE)
	`LEX_ASSERT_NEXT(a_eot_emits, clk, arst_n, accept && end_of_text, cnt_s1 != 2'd0)
	`LEX_ASSERT_IMP(a_no_push_idle, clk, arst_n, !$past(accept), cnt_s1 == 2'd0)
endmodule

### sv/csl_outq.sv
// ----------------------------------------------------------------------------
// csl_outq
// small token fifo between the scanner and the output channel
// ----------------------------------------------------------------------------
module csl_outq #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_count,
	input  logic [WIDTH-1:0] push_data [3],
	output logic [2:0]       free_slots,
	output logic             valid,
	input  logic             stall,
	output logic [WIDTH-1:0] data
);
	logic [WIDTH-1:0] mem_q [8];
	logic [2:0] rd_q;
	logic [2:0] wr_q;
	logic [3:0] cnt_q;
	logic pop;

	assign valid = cnt_q != 4'd0;
	assign pop = valid && !stall;
	assign data = mem_q[rd_q];
	assign free_slots = (cnt_q > 4'd7) ? 3'd0 : 3'(4'd7 - cnt_q);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < push_count) begin
				mem_q[3'(wr_q + 3'(i))] <= push_data[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= 3'(wr_q + 3'(push_count));
			if (pop) begin
				rd_q <= 3'(rd_q + 3'd1);
			end
			cnt_q <= 4'(cnt_q + 4'(push_count) - 4'(pop));
		end
	end
endmodule

### verif/c_subset_lexer_core_test.sv
// ----------------------------------------------------------------------------
// c_subset_lexer_core_test
// self-checking bench for the lexer: byte streams of small c programs and
// noise go in with random gaps, tokens are predicted per byte and compared
// field by field against the output channel under random back-pressure
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module c_subset_lexer_core_test;
	import csl_pkg::*;

	typedef struct packed {
		logic [3:0]  kind;
		logic [4:0]  op;
		logic [15:0] start;
		logic [15:0] len;
		logic [30:0] val;
		logic [1:0]  err;
		logic        last;
	} token_t;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic [30:0] VALUE_MAX = 31'h7fffffff;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] text_byte = 8'd0;
	logic end_of_text = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [3:0] token_kind;
	logic [4:0] operator_code;
	logic [15:0] start_offset;
	logic [15:0] token_length;
	logic [30:0] number_value;
	logic [1:0] error_code;
	logic last_result;

	c_subset_lexer_core uut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [2:0]  lx_mode = MODE_IDLE;
	logic [8:0]  lx_cand = '0;
	logic [15:0] lx_start = '0;
	logic [15:0] lx_pos = '0;
	logic [30:0] lx_acc = '0;
	logic [7:0]  lx_pend = '0;
	logic        lx_star = 1'b0;

	token_t expected_tokens[$];
	token_t step_tokens[$];
	int mismatches = 0;
	int tokens_seen = 0;
	int bytes_sent = 0;
	int texts_sent = 0;
	int idle_cycles = 0;
	bit stall_enable = 1'b1;

	function automatic string kw_word(int k);
		case (k)
			0: return "return";
			1: return "if";
			2: return "else";
			3: return "for";
			4: return "while";
			5: return "int";
			6: return "char";
			7: return "void";
			default: return "sizeof";
		endcase
	endfunction

	function automatic bit letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic int op_index(logic [7:0] c);
		string s;
		s = "+-*/()<>;={}&,[]";
		for (int k = 0; k < 16; k++)
			if (s[k] == c)
				return k;
		return -1;
	endfunction

	task automatic push_token(logic [3:0] kind, logic [4:0] op, logic [15:0] start,
			logic [15:0] len, logic [30:0] val, logic [1:0] err);
		token_t t;
		t = '{kind, op, start, len, val, err, 1'b0};
		if (step_tokens.size() < 3)
			step_tokens.push_back(t);
	endtask

	task automatic prune_keywords(int idx, logic [7:0] c);
		string w;
		for (int k = 0; k < NUM_KW; k++) begin
			w = kw_word(k);
			if (!(idx < w.len() && w[idx] == c))
				lx_cand[k] = 1'b0;
		end
	endtask

	task automatic close_word(bit kw_ok);
		logic [15:0] n;
		logic [3:0] kind;
		n = lx_pos - lx_start;
		kind = KIND_IDENT;
		if (kw_ok)
			for (int k = 0; k < NUM_KW; k++)
				if (lx_cand[k] && n == kw_word(k).len())
					kind = KIND_KW0 + 4'(k);
		push_token(kind, OP_NONE, lx_start, n, '0, ERR_NONE);
		lx_mode = MODE_IDLE;
	endtask

	task automatic close_pending();
		int code;
		code = op_index(lx_pend);
		if (code < 0)
			push_token(KIND_ERROR, OP_NONE, lx_start, 16'd1, '0, ERR_BADCHAR);
		else
			push_token(KIND_OPER, 5'(code), lx_start, 16'd1, '0, ERR_NONE);
		lx_mode = MODE_IDLE;
	endtask

	task automatic scan_fresh(logic [7:0] c);
		int code;
		lx_mode = MODE_IDLE;
		if (c == " " || (c >= 8'd9 && c <= 8'd13))
			return;
		if (letter(c)) begin
			lx_mode = MODE_WORD;
			lx_start = lx_pos;
			lx_cand = 9'h1ff;
			prune_keywords(0, c);
		end else if (digit(c)) begin
			lx_mode = MODE_NUM;
			lx_start = lx_pos;
			lx_acc = 31'(c - "0");
		end else if (c == "\"") begin
			lx_mode = MODE_STR;
			lx_start = lx_pos;
		end else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "+" || c == "-"
				|| c == "/") begin
			lx_mode = MODE_OPER;
			lx_start = lx_pos;
			lx_pend = c;
		end else begin
			code = op_index(c);
			if (code >= 0)
				push_token(KIND_OPER, 5'(code), lx_pos, 16'd1, '0, ERR_NONE);
			else
				push_token(KIND_ERROR, OP_NONE, lx_pos, 16'd1, '0, ERR_BADCHAR);
		end
	endtask

	task automatic predict_tokens(logic [7:0] c, logic eot);
		int code;
		logic [30:0] d;
		step_tokens.delete();
		if (eot) begin
			case (lx_mode)
				MODE_WORD: close_word(1'b1);
				MODE_NUM: push_token(KIND_NUMBER, OP_NONE, lx_start, lx_pos - lx_start,
					lx_acc, ERR_NONE);
				MODE_OPER: close_pending();
				MODE_STR: push_token(KIND_ERROR, OP_NONE, lx_start, lx_pos - lx_start,
					'0, ERR_STRING);
				MODE_BLOCK: push_token(KIND_ERROR, OP_NONE, lx_start, lx_pos - lx_start,
					'0, ERR_COMMENT);
				default: ;
			endcase
			push_token(KIND_END, OP_NONE, lx_pos, 16'd0, '0, ERR_NONE);
			lx_mode = MODE_IDLE;
			lx_cand = '0;
			lx_start = '0;
			lx_pos = '0;
			lx_acc = '0;
			lx_pend = '0;
			lx_star = 1'b0;
		end else begin
			case (lx_mode)
				MODE_WORD:
					if (letter(c))
						prune_keywords(int'(lx_pos - lx_start), c);
					else begin
						close_word(!(digit(c) || c == "_"));
						scan_fresh(c);
					end
				MODE_NUM:
					if (digit(c)) begin
						d = 31'(c - "0");
						if (lx_acc > (VALUE_MAX - d) / 10)
							lx_acc = VALUE_MAX;
						else
							lx_acc = lx_acc * 10 + d;
					end else begin
						push_token(KIND_NUMBER, OP_NONE, lx_start, lx_pos - lx_start,
							lx_acc, ERR_NONE);
						lx_mode = MODE_IDLE;
						scan_fresh(c);
					end
				MODE_STR:
					if (c == "\"") begin
						push_token(KIND_STRING, OP_NONE, lx_start, lx_pos - lx_start + 16'd1,
							'0, ERR_NONE);
						lx_mode = MODE_IDLE;
					end
				MODE_OPER: begin
					code = -1;
					if (c == "=" && lx_pend == "=") code = 16;
					if (c == "=" && lx_pend == "!") code = 17;
					if (c == "=" && lx_pend == "<") code = 18;
					if (c == "=" && lx_pend == ">") code = 19;
					if (c == "+" && lx_pend == "+") code = 20;
					if (c == "-" && lx_pend == "-") code = 21;
					if (code >= 0) begin
						push_token(KIND_OPER, 5'(code), lx_start, 16'd2, '0, ERR_NONE);
						lx_mode = MODE_IDLE;
					end else if (lx_pend == "/" && c == "/")
						lx_mode = MODE_LINE;
					else if (lx_pend == "/" && c == "*") begin
						lx_mode = MODE_BLOCK;
						lx_star = 1'b0;
					end else begin
						close_pending();
						scan_fresh(c);
					end
				end
				MODE_LINE:
					if (c == "\n")
						lx_mode = MODE_IDLE;
				MODE_BLOCK: begin
					if (lx_star && c == "/")
						lx_mode = MODE_IDLE;
					lx_star = (c == "*");
				end
				default: scan_fresh(c);
			endcase
			lx_pos = lx_pos + 16'd1;
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].last = 1'b1;
		foreach (step_tokens[i])
			expected_tokens.push_back(step_tokens[i]);
	endtask

	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		return (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
	endfunction

	task automatic send_word(logic [7:0] c, logic eot);
		int gap;
		in_valid <= 1'b1;
		text_byte <= eot ? 8'($urandom) : c;
		end_of_text <= eot;
		do @(posedge clk); while (in_stall);
		predict_tokens(c, eot);
		bytes_sent++;
		if (eot)
			texts_sent++;
		@(negedge clk);
		gap = random_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_text(string s, bit close);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], 1'b0);
		if (close)
			send_word(8'd0, 1'b1);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// output side
	always @(negedge clk) begin
		if (!stall_enable)
			out_stall <= 1'b0;
		else if ($urandom_range(0, 199) == 0)
			out_stall <= 1'b1;
		else if ($urandom_range(0, 2) == 0)
			out_stall <= ~out_stall;
		else if ($urandom_range(0, 9) == 0)
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		token_t got;
		token_t exp;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no progress in %0d cycles", WATCHDOG_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
			if (out_valid && !out_stall) begin
				got = '{token_kind, operator_code, start_offset, token_length, number_value,
					error_code, last_result};
				tokens_seen++;
				if (expected_tokens.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected token kind=%0d start=%0d", token_kind,
							start_offset);
				end else begin
					exp = expected_tokens.pop_front();
					if (got !== exp) begin
						mismatches++;
						if (mismatches <= 10)
							$display("token mismatch: exp k%0d op%0d s%0d l%0d v%0d e%0d t%0d",
								exp.kind, exp.op, exp.start, exp.len, exp.val, exp.err,
								exp.last, " got k%0d op%0d s%0d l%0d v%0d e%0d t%0d",
								got.kind, got.op, got.start, got.len, got.val, got.err,
								got.last);
					end
				end
			end
		end
	end

	task automatic test_keywords_and_words();
		send_text("return if else for while int char void sizeof", 1'b1);
		send_text("iff if_ int2 Zz sizeofx fo", 1'b1);
	endtask

	task automatic test_numbers();
		send_text("0 2147483647 99999999999 007", 1'b1);
	endtask

	task automatic test_operators();
		send_text("+-*/()<>;={}&,[]", 1'b0);
		send_text("== != <= >= ++ -- ! =", 1'b1);
	endtask

	task automatic test_strings_comments();
		send_text("\"ab c\" x//line\ny/*a**/z", 1'b1);
		send_text("a // open line", 1'b1);
		send_text("/* open", 1'b1);
		send_text("\"open", 1'b1);
	endtask

	task automatic test_bad_bytes();
		send_word(8'd0, 1'b0);
		send_word(8'hff, 1'b0);
		send_word(8'h80, 1'b0);
		send_word("_", 1'b0);
		send_word("/", 1'b1);
		send_word(8'd0, 1'b1);
	endtask

	task automatic test_random_programs(int budget);
		string frags[] = '{"int ", "x", "= ", "42", ";", "\n", "if (", "a<=b", ") {",
			"}", "return ", "i++", "--j", "\"s t\"", "/* c * */", "// r\n", "while",
			"[0]", "&y", ", ", "sizeof(char)", "void ", "!=", "\t", "123456789012",
			"else", "for(", "q_1", "v2"};
		string f;
		int n;
		n = 0;
		while (n < budget) begin
			if ($urandom_range(0, 9) < 7) begin
				repeat ($urandom_range(2, 10)) begin
					f = frags[$urandom_range(0, frags.size() - 1)];
					send_text(f, 1'b0);
					n += f.len();
				end
			end else begin
				repeat ($urandom_range(1, 6)) begin
					send_word(8'($urandom), 1'b0);
					n++;
				end
			end
			if ($urandom_range(0, 3) == 0) begin
				send_word(8'd0, 1'b1);
				n++;
			end
			if ($urandom_range(0, 20) == 0)
				wait_drained();
		end
		send_word(8'd0, 1'b1);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		stall_enable = 1'b0;
		test_keywords_and_words();
		stall_enable = 1'b1;
		test_numbers();
		test_operators();
		wait_drained();
		test_strings_comments();
		test_bad_bytes();
		test_random_programs(270);
		wait_drained();
		repeat (20) @(negedge clk);
		$display("sent %0d bytes in %0d texts, checked %0d tokens", bytes_sent, texts_sent,
			tokens_seen);
		if (mismatches == 0 && expected_tokens.size() == 0)
			$display("Regression PASS");
		else begin
			$display("%0d mismatches, %0d tokens missing", mismatches,
				expected_tokens.size());
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
